@@ src/isrm_pkg.sv @@
// Shared constants, codes and types for the ingress slot ring manager.
`default_nettype none
package isrm_pkg;

  localparam int SLOTS   = 16;
  localparam int SLOT_W  = 4;
  localparam int CNT_W   = 5;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 4;
  localparam int BYTES_W = 32;
  localparam int TIME_W  = 64;
  localparam int TOT_W   = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [FUNC_W-1:0] {
    F_ACQUIRE = 3'd0,
    F_COMMIT  = 3'd1,
    F_ABANDON = 3'd2,
    F_EXT     = 3'd3,
    F_POP     = 3'd4,
    F_RELEASE = 3'd5,
    F_POLL    = 3'd6,
    F_STOP    = 3'd7
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 4'd0,
    ST_MODE      = 4'd1,
    ST_BADSLOT   = 4'd2,
    ST_LARGE     = 4'd3,
    ST_NOTLATEST = 4'd4,
    ST_INFLIGHT  = 4'd5,
    ST_FULL      = 4'd6,
    ST_EMPTY     = 4'd7,
    ST_STOPPED   = 4'd8,
    ST_NOTDONE   = 4'd9
  } status_e;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_COMMITTED = 2'd1,
    PH_RELEASING = 2'd2
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL_MODE  = 2'd0,
    CFG_RING_SLOTS = 2'd1,
    CFG_BYTE_LIMIT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic               fill_mode;
    logic [CNT_W-1:0]   ring_slots;
    logic [BYTES_W-1:0] byte_limit;
  } cfg_t;

endpackage
`default_nettype wire

@@ src/isrm_if.sv @@
// Request and response channel interfaces of the slot ring manager.
`default_nettype none
interface isrm_req_if;
  logic                          valid;
  logic                          ready;
  logic [isrm_pkg::FUNC_W-1:0]   func;
  logic [isrm_pkg::SLOT_W-1:0]   slot_index;
  logic [isrm_pkg::TIME_W-1:0]   frame_time;
  logic [isrm_pkg::BYTES_W-1:0]  frame_bytes;
  logic                          upload_done;

  modport source (output valid, func, slot_index, frame_time, frame_bytes, upload_done,
                  input ready);
  modport sink   (input valid, func, slot_index, frame_time, frame_bytes, upload_done,
                  output ready);
endinterface

interface isrm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [isrm_pkg::STAT_W-1:0]   status;
  logic [isrm_pkg::SLOT_W-1:0]   slot_out;
  logic [isrm_pkg::BYTES_W-1:0]  out_bytes;
  logic [isrm_pkg::TIME_W-1:0]   out_time;
  logic [isrm_pkg::TOT_W-1:0]    committed_total;
  logic [isrm_pkg::TOT_W-1:0]    released_total;

  modport source (output valid, status, slot_out, out_bytes, out_time, committed_total,
                  released_total, input ready);
  modport sink   (input valid, status, slot_out, out_bytes, out_time, committed_total,
                  released_total, output ready);
endinterface
`default_nettype wire

@@ src/ingress_slot_ring_manager_core.sv @@
// Top level: configuration registers and the slot ring sequencer.
// Sequence: an accepted transaction is registered, then S_EXEC loads its result once the
// result register is free; a pop goes on to S_POP (ready-queue read, then slot metadata
// read from the second memory). One at a time: a new one is taken only in S_IDLE.
// Reset: asynchronous active low; counters cleared, run flag set, all slots idle,
// ready queue empty; configuration back to staged mode, 16 slots, 65536-byte limit.
`default_nettype none
module ingress_slot_ring_manager_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [isrm_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [isrm_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  isrm_req_if.sink                                req_if,
  isrm_rsp_if.source                              rsp_if
);
  import isrm_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fill_mode  <= 1'b0;
      cfg_q.ring_slots <= CNT_W'(SLOTS);
      cfg_q.byte_limit <= BYTES_W'(65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FILL_MODE:  cfg_q.fill_mode  <= cfg_wdata_i[0];
        CFG_RING_SLOTS: cfg_q.ring_slots <= cfg_wdata_i[CNT_W-1:0];
        CFG_BYTE_LIMIT: cfg_q.byte_limit <= cfg_wdata_i[BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  isrm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .req    (req_if),
    .rsp    (rsp_if)
  );

endmodule
`default_nettype wire

@@ src/isrm_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module isrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ src/isrm_ctrl.sv @@
// Operation sequencer: counters, slot phases, ready queue control and result register.
`default_nettype none
module isrm_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire isrm_pkg::cfg_t cfg_i,
  isrm_req_if.sink          req,
  isrm_rsp_if.source        rsp
);
  import isrm_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP
  } state_e;

  localparam int META_W = TIME_W + BYTES_W;

  state_e state_q;

  logic [FUNC_W-1:0]  func_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [TIME_W-1:0]  time_q;
  logic [BYTES_W-1:0] bytes_q;
  logic               done_q;

  logic [TOT_W-1:0]  acq_q, rel_q, cmt_q;
  logic [TOT_W-1:0]  acq_d, rel_d, cmt_d;
  logic              run_q;
  phase_e            phase_q [SLOTS];
  logic [SLOT_W-1:0] head_q;
  logic [CNT_W-1:0]  fill_q;

  // acquire_count modulo k for every ring size k
  logic [SLOT_W-1:0] res_q  [1:SLOTS];
  logic [SLOT_W-1:0] res_d  [1:SLOTS];
  logic [SLOT_W-1:0] maxres [1:SLOTS];

  logic               out_valid_q;
  logic [STAT_W-1:0]  status_q;
  logic [SLOT_W-1:0]  slot_out_q;
  logic [BYTES_W-1:0] out_bytes_q;
  logic [TIME_W-1:0]  out_time_q;
  logic [TOT_W-1:0]   cmt_out_q, rel_out_q;

  logic [SLOT_W-1:0]  q_rdata;
  logic [META_W-1:0]  meta_rdata;

  logic [CNT_W-1:0]  n;
  logic [SLOT_W-1:0] res_cur, latest;
  logic              slot_bad, too_large, not_latest, q_full, ring_full;
  logic              out_free, upd, out_load;
  status_e           status_d;
  logic [SLOT_W-1:0] slot_d;
  logic              acq_inc, acq_dec, push, pop_ok, rel_inc, poll_ok, stop;

  always_comb begin
    if (cfg_i.ring_slots == '0) begin
      n = CNT_W'(1);
    end else if (cfg_i.ring_slots > CNT_W'(SLOTS)) begin
      n = CNT_W'(SLOTS);
    end else begin
      n = cfg_i.ring_slots;
    end
  end

  assign res_cur = res_q[n];

  always_comb begin
    if (acq_q == '0) begin
      latest = maxres[n];
    end else if (res_cur == '0) begin
      latest = SLOT_W'(n - CNT_W'(1));
    end else begin
      latest = res_cur - SLOT_W'(1);
    end
  end

  assign slot_bad   = {1'b0, slot_q} >= n;
  assign too_large  = bytes_q > cfg_i.byte_limit;
  assign not_latest = (acq_q == cmt_q) || (slot_q != latest);
  assign q_full     = fill_q >= CNT_W'(SLOTS);
  assign ring_full  = (acq_q - rel_q) >= {{(TOT_W-CNT_W){1'b0}}, n};
  assign out_free   = !out_valid_q || rsp.ready;

  always_comb begin
    status_d = ST_OK;
    slot_d   = '0;
    acq_inc  = 1'b0;
    acq_dec  = 1'b0;
    push     = 1'b0;
    pop_ok   = 1'b0;
    rel_inc  = 1'b0;
    poll_ok  = 1'b0;
    stop     = 1'b0;
    case (func_e'(func_q))
      F_ACQUIRE: begin
        if (cfg_i.fill_mode) status_d = ST_MODE;
        else if (!run_q) status_d = ST_STOPPED;
        else if (ring_full) status_d = ST_FULL;
        else begin
          slot_d  = res_cur;
          acq_inc = 1'b1;
        end
      end
      F_COMMIT: begin
        if (cfg_i.fill_mode) status_d = ST_MODE;
        else if (slot_bad) status_d = ST_BADSLOT;
        else if (too_large) status_d = ST_LARGE;
        else if (not_latest) status_d = ST_NOTLATEST;
        else if (q_full) status_d = ST_FULL;
        else push = 1'b1;
      end
      F_ABANDON: begin
        if (cfg_i.fill_mode) status_d = ST_MODE;
        else if (not_latest) status_d = ST_NOTLATEST;
        else acq_dec = 1'b1;
      end
      F_EXT: begin
        if (!cfg_i.fill_mode) status_d = ST_MODE;
        else if (slot_bad) status_d = ST_BADSLOT;
        else if (too_large) status_d = ST_LARGE;
        else if (phase_q[slot_q] != PH_IDLE) status_d = ST_INFLIGHT;
        else if (q_full) status_d = ST_FULL;
        else push = 1'b1;
      end
      F_POP: begin
        if (!run_q) status_d = ST_STOPPED;
        else if (fill_q == '0) status_d = ST_EMPTY;
        else pop_ok = 1'b1;
      end
      F_RELEASE: begin
        if (slot_bad) status_d = ST_BADSLOT;
        else rel_inc = 1'b1;
      end
      F_POLL: begin
        if (slot_bad) status_d = ST_BADSLOT;
        else if (phase_q[slot_q] != PH_RELEASING || !done_q) status_d = ST_NOTDONE;
        else poll_ok = 1'b1;
      end
      F_STOP: stop = 1'b1;
      default: stop = 1'b1;
    endcase
  end

  // non-pop state commits when the result register can take this transaction
  assign upd = (state_q == S_EXEC) && !pop_ok && out_free;
  assign out_load = upd || ((state_q == S_POP) && out_free);

  assign acq_d = (upd && acq_inc) ? acq_q + TOT_W'(1) :
                 (upd && acq_dec) ? acq_q - TOT_W'(1) : acq_q;
  assign cmt_d = (upd && push) ? cmt_q + TOT_W'(1) : cmt_q;
  assign rel_d = (upd && rel_inc) ? rel_q + TOT_W'(1) : rel_q;

  for (genvar k = 1; k <= SLOTS; k++) begin : g_res
    localparam logic [TOT_W-1:0]  MAXR = {TOT_W{1'b1}} % k;
    localparam logic [SLOT_W-1:0] KM1  = SLOT_W'(k - 1);
    logic [SLOT_W-1:0] inc_v, dec_v;
    assign maxres[k] = SLOT_W'(MAXR);
    assign inc_v = (acq_q == {TOT_W{1'b1}} || res_q[k] == KM1) ? '0 : res_q[k] + SLOT_W'(1);
    assign dec_v = (acq_q == '0) ? maxres[k] :
                   (res_q[k] == '0) ? KM1 : res_q[k] - SLOT_W'(1);
    assign res_d[k] = (upd && acq_inc) ? inc_v :
                      (upd && acq_dec) ? dec_v : res_q[k];
  end

  isrm_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_queue (
    .clk_i   (clk_i),
    .we_i    (upd && push),
    .waddr_i (head_q + fill_q[SLOT_W-1:0]),
    .wdata_i (slot_q),
    .re_i    (req.valid && state_q == S_IDLE),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  isrm_ram #(.WIDTH(META_W), .DEPTH(SLOTS)) u_meta (
    .clk_i   (clk_i),
    .we_i    (upd && push),
    .waddr_i (slot_q),
    .wdata_i ({time_q, bytes_q}),
    .re_i    (state_q == S_EXEC && pop_ok),
    .raddr_i (q_rdata),
    .rdata_o (meta_rdata)
  );

  assign req.ready           = (state_q == S_IDLE);
  assign rsp.valid           = out_valid_q;
  assign rsp.status          = status_q;
  assign rsp.slot_out        = slot_out_q;
  assign rsp.out_bytes       = out_bytes_q;
  assign rsp.out_time        = out_time_q;
  assign rsp.committed_total = cmt_out_q;
  assign rsp.released_total  = rel_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= '0;
      slot_q      <= '0;
      time_q      <= '0;
      bytes_q     <= '0;
      done_q      <= 1'b0;
      acq_q       <= '0;
      rel_q       <= '0;
      cmt_q       <= '0;
      run_q       <= 1'b1;
      head_q      <= '0;
      fill_q      <= '0;
      for (int i = 0; i < SLOTS; i++) phase_q[i] <= PH_IDLE;
      for (int k = 1; k <= SLOTS; k++) res_q[k] <= '0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      slot_out_q  <= '0;
      out_bytes_q <= '0;
      out_time_q  <= '0;
      cmt_out_q   <= '0;
      rel_out_q   <= '0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (rsp.ready) out_valid_q <= 1'b0;
      acq_q <= acq_d;
      cmt_q <= cmt_d;
      rel_q <= rel_d;
      for (int k = 1; k <= SLOTS; k++) res_q[k] <= res_d[k];
      case (state_q)
        S_IDLE: begin
          if (req.valid) begin
            func_q  <= req.func;
            slot_q  <= req.slot_index;
            time_q  <= req.frame_time;
            bytes_q <= req.frame_bytes;
            done_q  <= req.upload_done;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (pop_ok) begin
            head_q  <= head_q + SLOT_W'(1);
            fill_q  <= fill_q - CNT_W'(1);
            state_q <= S_POP;
          end else if (out_free) begin
            if (push) begin
              phase_q[slot_q] <= PH_COMMITTED;
              fill_q          <= fill_q + CNT_W'(1);
            end
            if (rel_inc) phase_q[slot_q] <= PH_RELEASING;
            if (poll_ok) phase_q[slot_q] <= PH_IDLE;
            if (stop) run_q <= 1'b0;
            status_q    <= status_d;
            slot_out_q  <= slot_d;
            out_bytes_q <= '0;
            out_time_q  <= '0;
            cmt_out_q   <= cmt_d;
            rel_out_q   <= rel_d;
            state_q     <= S_IDLE;
          end
        end
        S_POP: begin
          if (out_free) begin
            status_q    <= ST_OK;
            slot_out_q  <= q_rdata;
            out_bytes_q <= meta_rdata[BYTES_W-1:0];
            out_time_q  <= meta_rdata[META_W-1:BYTES_W];
            cmt_out_q   <= cmt_q;
            rel_out_q   <= rel_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
